/* design/plbs_pkg.sv */
// ----------------------------------------------------------------------------
// plbs_pkg
// Shared types, constants and helpers of the parameter link byte slave.
// ----------------------------------------------------------------------------
package plbs_pkg;

  localparam int MAX_PARAMS  = 256;
  localparam int DESC_LEN    = 33;
  localparam int DESC_DEPTH  = MAX_PARAMS * DESC_LEN;
  localparam int ADDR_W      = $clog2(DESC_DEPTH);
  localparam int VALUE_BYTES = 4;
  localparam int CFG_IDX_W   = 2;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_PARAMS = 2'd0,
    CFG_OP_SET     = 2'd1,
    CFG_OP_COUNT   = 2'd2,
    CFG_OP_DESC    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] num_params;
    logic [7:0] op_set_param;
    logic [7:0] op_get_count;
    logic [7:0] op_get_desc;
  } cfg_t;

  // One item's answer as decided by the command machine
  typedef struct packed {
    logic        use_mem;  // tx comes from the descriptor RAM
    logic        rd_ok;    // descriptor index in range
    logic [7:0]  tx;       // tx when not from RAM
    logic        upd;
    logic [7:0]  uidx;
    logic [31:0] uval;
  } resp_t;

  function automatic logic [ADDR_W-1:0] desc_addr(input logic [7:0] idx,
                                                 input logic [5:0] pos);
    logic [ADDR_W-1:0] base;
    base      = ADDR_W'(idx) * ADDR_W'(DESC_LEN);
    desc_addr = base + ADDR_W'(pos);
  endfunction

  function automatic logic desc_idx_ok(input logic [7:0] idx);
    desc_idx_ok = (int'(idx) < MAX_PARAMS);
  endfunction

endpackage

/* design/plbs_ram.sv */
// ----------------------------------------------------------------------------
// plbs_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module plbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/plbs_cmd_fsm.sv */
// ----------------------------------------------------------------------------
// plbs_cmd_fsm
// Command machine: decodes link bytes, assembles set values, issues
// descriptor reads.
// ----------------------------------------------------------------------------
module plbs_cmd_fsm
  import plbs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,     // link byte accepted
  input  logic [7:0]        rx_byte_i,
  input  cfg_t              cfg_i,
  output resp_t             resp_o,
  output logic [ADDR_W-1:0] rd_addr_o
);

  typedef enum logic [2:0] {
    PH_CMD        = 3'd0,
    PH_SET_IDX    = 3'd1,
    PH_SET_DATA   = 3'd2,
    PH_COUNT_TAIL = 3'd3,
    PH_DESC_IDX   = 3'd4,
    PH_DESC_DATA  = 3'd5
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  cur_idx_q, cur_idx_d;
  logic [5:0]  pos_q, pos_d;
  logic [23:0] va_q, va_d;
  logic [7:0]  rd_idx;
  logic [5:0]  rd_pos;

  always_comb begin
    phase_d   = phase_q;
    cur_idx_d = cur_idx_q;
    pos_d     = pos_q;
    va_d      = va_q;
    resp_o    = '0;
    rd_idx    = cur_idx_q;
    rd_pos    = pos_q;
    unique case (phase_q)
      PH_CMD: begin
        priority if (rx_byte_i == cfg_i.op_set_param) begin
          phase_d = PH_SET_IDX;
        end else if (rx_byte_i == cfg_i.op_get_count) begin
          phase_d   = PH_COUNT_TAIL;
          resp_o.tx = cfg_i.num_params;
        end else if (rx_byte_i == cfg_i.op_get_desc) begin
          phase_d = PH_DESC_IDX;
        end else begin
          phase_d = PH_CMD;
        end
      end
      PH_SET_IDX: begin
        cur_idx_d = rx_byte_i;
        pos_d     = '0;
        va_d      = '0;
        phase_d   = PH_SET_DATA;
      end
      PH_SET_DATA: begin
        if (pos_q < 6'(VALUE_BYTES - 1)) begin
          va_d  = {va_q[15:0], rx_byte_i};
          pos_d = pos_q + 6'd1;
        end else begin
          resp_o.upd  = 1'b1;
          resp_o.uidx = cur_idx_q;
          resp_o.uval = {va_q, rx_byte_i};
          pos_d       = '0;
          phase_d     = PH_CMD;
        end
      end
      PH_COUNT_TAIL: begin
        phase_d = PH_CMD;
      end
      PH_DESC_IDX: begin
        cur_idx_d      = rx_byte_i;
        rd_idx         = rx_byte_i;
        rd_pos         = '0;
        resp_o.use_mem = 1'b1;
        resp_o.rd_ok   = desc_idx_ok(rx_byte_i);
        pos_d          = 6'd1;
        phase_d        = PH_DESC_DATA;
      end
      PH_DESC_DATA: begin
        if (pos_q < 6'(DESC_LEN)) begin
          resp_o.use_mem = 1'b1;
          resp_o.rd_ok   = desc_idx_ok(cur_idx_q);
          pos_d          = pos_q + 6'd1;
        end else begin
          pos_d   = '0;
          phase_d = PH_CMD;
        end
      end
      default: begin
        phase_d = PH_CMD;
      end
    endcase
  end

  assign rd_addr_o = desc_addr(rd_idx, rd_pos);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_CMD;
      cur_idx_q <= '0;
      pos_q     <= '0;
      va_q      <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      cur_idx_q <= cur_idx_d;
      pos_q     <= pos_d;
      va_q      <= va_d;
    end
  end

endmodule

/* design/param_link_byte_slave_core.sv */
// ----------------------------------------------------------------------------
// param_link_byte_slave_core
// Byte-wise parameter link slave with descriptor RAM and output register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): cmd_i = 0 carries a received
//   link byte in rx_byte_i; cmd_i = 1 writes load_byte_i into the descriptor
//   RAM at (load_index_i, load_offset_i). Out-of-range loads are dropped.
//   Every accepted item gives exactly one result item on the output channel
//   (out_valid_o / out_stall_i): tx_byte_o is the byte to shift out next, and
//   update_* report a finished set-param command.
//   An accepted item passes the read stage, then the output register.
//   Throughput: one item per clock; each link byte costs at most one read of
//   the descriptor RAM, whose registered read port sets the two-stage pipe.
//   The input is stalled only while a result waits in the read stage and the
//   output register is full and stalled; the RAM read data is held then.
//   Reset clears the command machine, the pipeline valids and loads the
//   register reset values. The descriptor RAM is not cleared: an entry must
//   be loaded before a get-descriptor reads it. Configuration (cfg_we_i /
//   cfg_idx_i / cfg_wdata_i) must be written while idle; not enforced.
// ----------------------------------------------------------------------------
module param_link_byte_slave_core
  import plbs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]           cfg_wdata_i,
  // input items
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 cmd_i,
  input  logic [7:0]           rx_byte_i,
  input  logic [7:0]           load_index_i,
  input  logic [5:0]           load_offset_i,
  input  logic [7:0]           load_byte_i,
  // result items
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           tx_byte_o,
  output logic                 update_valid_o,
  output logic [7:0]           update_index_o,
  output logic [31:0]          update_value_o
);

  cfg_t              cfg_q;
  resp_t             fsm_resp;
  resp_t             s1_resp_q;
  logic              s1_valid_q;
  logic              s1_adv;
  logic              in_acc;
  logic              link_step;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic              wr_en;
  logic [7:0]        rd_data;
  logic [7:0]        s1_tx;

  logic              out_valid_q;
  logic [7:0]        tx_q;
  logic              upd_q;
  logic [7:0]        uidx_q;
  logic [31:0]       uval_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_params   <= 8'd0;
      cfg_q.op_set_param <= 8'd0;
      cfg_q.op_get_count <= 8'd2;
      cfg_q.op_get_desc  <= 8'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NUM_PARAMS: cfg_q.num_params   <= cfg_wdata_i;
        CFG_OP_SET:     cfg_q.op_set_param <= cfg_wdata_i;
        CFG_OP_COUNT:   cfg_q.op_get_count <= cfg_wdata_i;
        CFG_OP_DESC:    cfg_q.op_get_desc  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Handshake: read stage moves on when the output register is free
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign link_step  = in_acc && !cmd_i;

  plbs_cmd_fsm u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (link_step),
    .rx_byte_i (rx_byte_i),
    .cfg_i     (cfg_q),
    .resp_o    (fsm_resp),
    .rd_addr_o (rd_addr)
  );

  // Descriptor loads; a write is never followed by a same-cycle read
  assign wr_addr = desc_addr(load_index_i, load_offset_i);
  assign wr_en   = in_acc && cmd_i && desc_idx_ok(load_index_i)
                   && (load_offset_i < 6'(DESC_LEN));

  plbs_ram #(
    .WIDTH (8),
    .DEPTH (DESC_DEPTH)
  ) u_desc_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (load_byte_i),
    .re_i    (link_step && fsm_resp.use_mem),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Read stage: holds the decided answer while the RAM read completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      // store writes answer with an all-zero item
      s1_resp_q <= cmd_i ? '0 : fsm_resp;
    end
  end

  always_comb begin
    if (s1_resp_q.use_mem) begin
      s1_tx = s1_resp_q.rd_ok ? rd_data : 8'd0;
    end else begin
      s1_tx = s1_resp_q.tx;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      tx_q   <= s1_tx;
      upd_q  <= s1_resp_q.upd;
      uidx_q <= s1_resp_q.uidx;
      uval_q <= s1_resp_q.uval;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign tx_byte_o      = tx_q;
  assign update_valid_o = upd_q;
  assign update_index_o = uidx_q;
  assign update_value_o = uval_q;

endmodule

/* design/plbs_checker.sv */
// ----------------------------------------------------------------------------
// plbs_checker
// Port-level checks of the parameter link byte slave, bound to the top level.
// ----------------------------------------------------------------------------
module plbs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  tx_byte_o,
  input logic        update_valid_o,
  input logic [7:0]  update_index_o,
  input logic [31:0] update_value_o
);

  // output item holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(tx_byte_o) && $stable(update_valid_o)
      && $stable(update_index_o) && $stable(update_value_o))
    else $error("stalled result changed");

  // input back-pressure only comes from a backed-up output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // a finished set command sends no data byte
  a_upd_tx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && update_valid_o |-> tx_byte_o == 8'd0)
    else $error("update item carries a tx byte");

  // update fields are zero outside an update
  a_no_upd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !update_valid_o |-> update_index_o == 8'd0
      && update_value_o == 32'd0)
    else $error("update fields set without update");

endmodule

bind param_link_byte_slave_core plbs_checker u_plbs_checker (.*);

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for param_link_byte_slave_core. A directed table covers
// the reset state, opcode extremes and the store corner cases, then random
// command sequences with descriptor loads and reads run through eight phases
// of register settings and idling. Results are compared with a cycle-free
// model of the command machine and descriptor store.
// ----------------------------------------------------------------------------
module tb_top
  import plbs_pkg::*;
();

  localparam logic CMD_LINK       = 1'b0;
  localparam logic CMD_STORE      = 1'b1;
  localparam int   PHASES         = 8;
  localparam int   TOTAL_ITEMS    = 1950;
  localparam int   WATCHDOG_LIMIT = 2000;
  localparam int   HOLD_CYCLES    = 80;
  localparam int   SETTLE_CYCLES  = 4;
  localparam int   MAX_GAP        = 60;

  // Command machine phases of the model
  typedef enum logic [2:0] {
    LK_IDLE,
    LK_SET_IDX,
    LK_SET_VAL,
    LK_CNT_TAIL,
    LK_DESC_IDX,
    LK_DESC_DATA
  } link_phase_e;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic [7:0]  tx;
    logic        upd;
    logic [7:0]  uidx;
    logic [31:0] uval;
  } answer_t;

  // One input item; typed marks a row whose answer is written out by hand
  typedef struct packed {
    logic       cmd;
    logic [7:0] rx;
    logic [7:0] li;
    logic [5:0] lo;
    logic [7:0] lb;
    logic       typed;
    answer_t    exp;
  } link_item_t;

  // --------------------------------------------------------------------------
  // DUT ports, inputs all known from time zero
  // --------------------------------------------------------------------------
  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = CFG_NUM_PARAMS;
  logic [7:0]           cfg_wdata_i   = '0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_stall_o;
  logic                 cmd_i         = CMD_LINK;
  logic [7:0]           rx_byte_i     = '0;
  logic [7:0]           load_index_i  = '0;
  logic [5:0]           load_offset_i = '0;
  logic [7:0]           load_byte_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i   = 1'b0;
  logic [7:0]           tx_byte_o;
  logic                 update_valid_o;
  logic [7:0]           update_index_o;
  logic [31:0]          update_value_o;

  param_link_byte_slave_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .rx_byte_i      (rx_byte_i),
    .load_index_i   (load_index_i),
    .load_offset_i  (load_offset_i),
    .load_byte_i    (load_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .tx_byte_o      (tx_byte_o),
    .update_valid_o (update_valid_o),
    .update_index_o (update_index_o),
    .update_value_o (update_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Model state: register copies, command machine, descriptor store
  // --------------------------------------------------------------------------
  logic [7:0]          reg_num     = 8'd0;
  logic [7:0]          reg_op_set  = 8'd0;
  logic [7:0]          reg_op_cnt  = 8'd2;
  logic [7:0]          reg_op_desc = 8'd3;
  link_phase_e         lk_phase    = LK_IDLE;
  logic [7:0]          lk_index    = '0;
  logic [5:0]          lk_pos      = '0;
  logic [23:0]         lk_acc      = '0;
  logic [7:0]          desc_mem     [MAX_PARAMS][DESC_LEN];
  logic [DESC_LEN-1:0] desc_written [MAX_PARAMS] = '{default: '0};
  logic [7:0]          loaded_q [$];  // indexes whose 33 bytes are all written
  answer_t             answer_q [$];  // answers still owed by the block

  link_item_t cur_item   = '0;  // item on the input port right now
  idle_mode_e idle_mode  = IDLE_NONE;
  int         send_pct   = 0;
  int         recv_pct   = 0;
  bit         hold_req   = 1'b0;
  int         hold_left  = 0;
  int         errors     = 0;
  int         results    = 0;
  int         updates    = 0;
  int         desc_reads = 0;
  int         items_sent = 0;
  int         quiet      = 0;

  function automatic logic [7:0] desc_byte(input logic [7:0] idx, input logic [5:0] pos);
    if (int'(idx) >= MAX_PARAMS || int'(pos) >= DESC_LEN) return 8'h00;
    return desc_mem[idx][pos];
  endfunction

  // Advance the model by one item and return the answer it owes
  function automatic answer_t predict_answer(input link_item_t it);
    answer_t a;
    a = '0;
    if (it.cmd == CMD_STORE) begin
      // out-of-range loads are dropped without a trace
      if (int'(it.li) < MAX_PARAMS && int'(it.lo) < DESC_LEN) begin
        desc_mem[it.li][it.lo] = it.lb;
        if (desc_written[it.li] != '1) begin
          desc_written[it.li][it.lo] = 1'b1;
          if (desc_written[it.li] == '1) loaded_q.push_back(it.li);
        end
      end
    end else begin
      case (lk_phase)
        LK_IDLE: begin
          // priority on equal opcodes: set, then count, then descriptor
          if (it.rx == reg_op_set) begin
            lk_phase = LK_SET_IDX;
          end else if (it.rx == reg_op_cnt) begin
            lk_phase = LK_CNT_TAIL;
            a.tx     = reg_num;
          end else if (it.rx == reg_op_desc) begin
            lk_phase = LK_DESC_IDX;
          end
        end
        LK_SET_IDX: begin
          lk_index = it.rx;
          lk_pos   = '0;
          lk_acc   = '0;
          lk_phase = LK_SET_VAL;
        end
        LK_SET_VAL: begin
          if (lk_pos < 6'd3) begin
            lk_acc = {lk_acc[15:0], it.rx};
            lk_pos = lk_pos + 6'd1;
          end else begin
            a.upd    = 1'b1;
            a.uidx   = lk_index;
            a.uval   = {lk_acc, it.rx};
            lk_pos   = '0;
            lk_phase = LK_IDLE;
          end
        end
        LK_CNT_TAIL: lk_phase = LK_IDLE;
        LK_DESC_IDX: begin
          lk_index   = it.rx;
          a.tx       = desc_byte(lk_index, 6'd0);
          lk_pos     = 6'd1;
          lk_phase   = LK_DESC_DATA;
          desc_reads = desc_reads + 1;
        end
        LK_DESC_DATA: begin
          if (int'(lk_pos) < DESC_LEN) begin
            a.tx   = desc_byte(lk_index, lk_pos);
            lk_pos = lk_pos + 6'd1;
          end else begin
            lk_pos   = '0;
            lk_phase = LK_IDLE;
          end
        end
        default: lk_phase = LK_IDLE;
      endcase
    end
    return a;
  endfunction

  // --------------------------------------------------------------------------
  // Sampling at the rising edge: check results, then predict the accepted
  // item, then track register writes. An item accepted here cannot have its
  // result at this same edge, so the order inside the block is harmless.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (answer_q.size() == 0) begin
          errors = errors + 1;
          $display("%0t: result with nothing expected: tx %02h upd %0b idx %02h val %08h",
                   $time, tx_byte_o, update_valid_o, update_index_o, update_value_o);
        end else begin
          want    = answer_q.pop_front();
          results = results + 1;
          if (update_valid_o) updates = updates + 1;
          if (tx_byte_o !== want.tx) begin
            errors = errors + 1;
            $display("%0t: tx_byte expected %02h actual %02h", $time, want.tx, tx_byte_o);
          end
          if (update_valid_o !== want.upd) begin
            errors = errors + 1;
            $display("%0t: update_valid expected %0b actual %0b",
                     $time, want.upd, update_valid_o);
          end
          if (update_index_o !== want.uidx) begin
            errors = errors + 1;
            $display("%0t: update_index expected %02h actual %02h",
                     $time, want.uidx, update_index_o);
          end
          if (update_value_o !== want.uval) begin
            errors = errors + 1;
            $display("%0t: update_value expected %08h actual %08h",
                     $time, want.uval, update_value_o);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        want = predict_answer(cur_item);
        answer_q.push_back(cur_item.typed ? cur_item.exp : want);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NUM_PARAMS: reg_num     = cfg_wdata_i;
          CFG_OP_SET:     reg_op_set  = cfg_wdata_i;
          CFG_OP_COUNT:   reg_op_cnt  = cfg_wdata_i;
          CFG_OP_DESC:    reg_op_desc = cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // Watchdog: any stretch with no handshake and no register write this long
  // means the block has hung.
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet = 0;
    else
      quiet = quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d answers outstanding",
               $time, quiet, answer_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver: random stall per the idle mode, or a long hold-off on request
  // so the pipe fills and the input side backs up.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   = hold_left - 1;
    end else if (hold_req) begin
      hold_req    = 1'b0;
      hold_left   = HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= (recv_pct != 0) && ($urandom_range(99) < recv_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Item builders
  // --------------------------------------------------------------------------
  function automatic logic [7:0] any_byte();
    logic [7:0] b;
    case ($urandom_range(5))
      0:       b = 8'h00;
      1:       b = 8'hFF;
      default: b = 8'($urandom);
    endcase
    return b;
  endfunction

  // Link byte; the load fields carry junk the block must ignore
  function automatic link_item_t link_byte(input logic [7:0] b);
    link_item_t it;
    it     = '0;
    it.cmd = CMD_LINK;
    it.rx  = b;
    it.li  = 8'($urandom);
    it.lo  = 6'($urandom);
    it.lb  = 8'($urandom);
    return it;
  endfunction

  function automatic link_item_t store_byte(input logic [7:0] idx, input logic [5:0] off,
                                            input logic [7:0] b);
    link_item_t it;
    it     = '0;
    it.cmd = CMD_STORE;
    it.rx  = 8'($urandom);
    it.li  = idx;
    it.lo  = off;
    it.lb  = b;
    return it;
  endfunction

  function automatic link_item_t typed(input link_item_t it, input logic [7:0] tx,
                                       input logic upd, input logic [7:0] uidx,
                                       input logic [31:0] uval);
    link_item_t t;
    t          = it;
    t.typed    = 1'b1;
    t.exp.tx   = tx;
    t.exp.upd  = upd;
    t.exp.uidx = uidx;
    t.exp.uval = uval;
    return t;
  endfunction

  // --------------------------------------------------------------------------
  // Driving: everything changes at the falling edge
  // --------------------------------------------------------------------------
  task automatic send(input link_item_t it);
    int gap;
    gap = 0;
    while (send_pct != 0 && gap < MAX_GAP && $urandom_range(99) < send_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    // an index byte of get-descriptor only ever names a fully loaded entry
    if (it.cmd == CMD_LINK && lk_phase == LK_DESC_IDX)
      it.rx = loaded_q[$urandom_range(loaded_q.size() - 1)];
    cur_item      <= it;
    cmd_i         <= it.cmd;
    rx_byte_i     <= it.rx;
    load_index_i  <= it.li;
    load_offset_i <= it.lo;
    load_byte_i   <= it.lb;
    in_valid_i    <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    if (it.cmd == CMD_LINK || int'(it.lo) < DESC_LEN) items_sent++;
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (answer_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [7:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
  endtask

  task automatic write_regs(input logic [7:0] num, input logic [7:0] op_set,
                            input logic [7:0] op_cnt, input logic [7:0] op_desc);
    write_reg(CFG_NUM_PARAMS, num);
    write_reg(CFG_OP_SET, op_set);
    write_reg(CFG_OP_COUNT, op_cnt);
    write_reg(CFG_OP_DESC, op_desc);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Command sequences
  // --------------------------------------------------------------------------
  // Flush whatever command is half done with random bytes
  task automatic to_idle();
    while (lk_phase != LK_IDLE) send(link_byte(8'($urandom)));
  endtask

  task automatic run_set();
    to_idle();
    send(link_byte(reg_op_set));
    for (int k = 0; k < 5; k++) begin
      if ($urandom_range(4) == 0) send(store_byte(8'($urandom), 6'($urandom), 8'($urandom)));
      send(link_byte(any_byte()));
    end
  endtask

  task automatic run_count();
    to_idle();
    send(link_byte(reg_op_cnt));
    send(link_byte(any_byte()));
  endtask

  // Index byte, 32 data bytes and the trailing zero. Store writes to the
  // entry being read are slipped in to hit the write-then-read ordering.
  task automatic run_desc();
    to_idle();
    send(link_byte(reg_op_desc));
    for (int k = 0; k < DESC_LEN + 1; k++) begin
      if (lk_phase == LK_DESC_DATA && $urandom_range(3) == 0)
        send(store_byte(lk_index, 6'($urandom_range(DESC_LEN - 1)), any_byte()));
      send(link_byte(8'($urandom)));
    end
  endtask

  task automatic run_load(input logic [7:0] idx, input bit fill_en, input logic [7:0] fill);
    int start;
    start = $urandom_range(DESC_LEN - 1);
    for (int k = 0; k < DESC_LEN; k++)
      send(store_byte(idx, 6'((start + k) % DESC_LEN), fill_en ? fill : any_byte()));
  endtask

  // Stray bytes and loads, offsets over the whole 6-bit range
  task automatic run_noise();
    int n;
    n = $urandom_range(4, 1);
    repeat (n) begin
      if ($urandom_range(1) == 0) send(link_byte(8'($urandom)));
      else send(store_byte(8'($urandom), 6'($urandom), 8'($urandom)));
    end
  endtask

  task automatic run_random(input int upto);
    int pick;
    while (items_sent < upto) begin
      pick = $urandom_range(99);
      if (pick < 30)      run_set();
      else if (pick < 45) run_count();
      else if (pick < 60) run_desc();
      else if (pick < 68) run_load(8'($urandom), 1'b0, 8'h00);
      else                run_noise();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    link_item_t dir_tab [$];
    int         upto;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed rows, reset settings: set 00, count 02, descriptor 03, count 0
    dir_tab.push_back(typed(link_byte(8'h02), 8'h00, 1'b0, 8'h00, 32'h0));  // count is 0
    dir_tab.push_back(typed(link_byte(8'hA5), 8'h00, 1'b0, 8'h00, 32'h0));  // count tail
    dir_tab.push_back(typed(link_byte(8'h01), 8'h00, 1'b0, 8'h00, 32'h0));  // get-param, no opcode here
    dir_tab.push_back(typed(link_byte(8'hFF), 8'h00, 1'b0, 8'h00, 32'h0));  // unknown
    dir_tab.push_back(typed(store_byte(8'hFF, 6'd32, 8'hFF), 8'h00, 1'b0, 8'h00, 32'h0));
    dir_tab.push_back(typed(store_byte(8'h00, 6'd33, 8'hAA), 8'h00, 1'b0, 8'h00, 32'h0));
    dir_tab.push_back(typed(store_byte(8'h80, 6'd63, 8'h55), 8'h00, 1'b0, 8'h00, 32'h0));
    // set-param with all-ones index and value
    dir_tab.push_back(typed(link_byte(8'h00), 8'h00, 1'b0, 8'h00, 32'h0));
    dir_tab.push_back(typed(link_byte(8'hFF), 8'h00, 1'b0, 8'h00, 32'h0));
    dir_tab.push_back(typed(link_byte(8'hFF), 8'h00, 1'b0, 8'h00, 32'h0));
    dir_tab.push_back(typed(link_byte(8'hFF), 8'h00, 1'b0, 8'h00, 32'h0));
    dir_tab.push_back(typed(link_byte(8'hFF), 8'h00, 1'b0, 8'h00, 32'h0));
    dir_tab.push_back(typed(link_byte(8'hFF), 8'h00, 1'b1, 8'hFF, 32'hFFFF_FFFF));
    // set-param with all-zero index and value
    dir_tab.push_back(typed(link_byte(8'h00), 8'h00, 1'b0, 8'h00, 32'h0));
    dir_tab.push_back(typed(link_byte(8'h00), 8'h00, 1'b0, 8'h00, 32'h0));
    dir_tab.push_back(typed(link_byte(8'h00), 8'h00, 1'b0, 8'h00, 32'h0));
    dir_tab.push_back(typed(link_byte(8'h00), 8'h00, 1'b0, 8'h00, 32'h0));
    dir_tab.push_back(typed(link_byte(8'h00), 8'h00, 1'b0, 8'h00, 32'h0));
    dir_tab.push_back(typed(link_byte(8'h00), 8'h00, 1'b1, 8'h00, 32'h0));
    // byte order check, with a store write in the middle that must not disturb
    dir_tab.push_back(link_byte(8'h00));
    dir_tab.push_back(link_byte(8'h5A));
    dir_tab.push_back(link_byte(8'h12));
    dir_tab.push_back(store_byte(8'h01, 6'd0, 8'h3C));
    dir_tab.push_back(link_byte(8'h34));
    dir_tab.push_back(link_byte(8'h56));
    dir_tab.push_back(typed(link_byte(8'h78), 8'h00, 1'b1, 8'h5A, 32'h1234_5678));
    foreach (dir_tab[i]) send(dir_tab[i]);

    // Fully load the two extreme indexes, then read descriptors back from them
    run_load(8'hFF, 1'b1, 8'hFF);
    run_load(8'h00, 1'b0, 8'h00);
    run_desc();
    run_desc();

    upto = TOTAL_ITEMS / PHASES;
    run_random(upto / 2);
    wait_drain();  // sender pauses until every answer is in
    run_random(upto);

    for (int p = 1; p < PHASES; p++) begin
      wait_drain();
      case (p)
        1: write_regs(8'hFF, 8'hFF, 8'h00, 8'h80);
        2: write_regs(8'h07, 8'h5A, 8'h5A, 8'h5A);  // all equal: set-param wins
        3: write_regs(8'h80, 8'h11, 8'h22, 8'h22);  // count shadows descriptor
        4: write_regs(8'h00, 8'h00, 8'hFF, 8'hFE);
        default: write_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      idle_mode = idle_mode_e'(p % 4);
      send_pct  = (idle_mode == IDLE_SEND) ? 81 : (idle_mode == IDLE_BOTH) ? 24 : 0;
      recv_pct  = (idle_mode == IDLE_RECV) ? 81 : (idle_mode == IDLE_BOTH) ? 24 : 0;
      // long receiver hold-off while the sender keeps pushing back to back
      if (idle_mode == IDLE_NONE) hold_req = 1'b1;
      upto = TOTAL_ITEMS * (p + 1) / PHASES;
      run_random(upto - TOTAL_ITEMS / PHASES / 2);
      wait_drain();
      run_random(upto);
    end

    in_valid_i <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Covered %0d items over %0d register/idle phases, %0d results checked.",
             items_sent, PHASES, results);
    $display("%0d parameter updates, %0d descriptor reads, %0d descriptors fully loaded.",
             updates, desc_reads, loaded_q.size());
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/plbs_pkg.sv
design/plbs_ram.sv
design/plbs_cmd_fsm.sv
design/param_link_byte_slave_core.sv
design/plbs_checker.sv
bench/tb_top.sv
